>>> design/gpsp_pkg.sv
// shared types and constants of the game pad serial port
package gpsp_pkg;

	typedef enum logic [2:0] {
		ACT_READ   = 3'd0,
		ACT_WRITE  = 3'd1,
		ACT_TICK   = 3'd2,
		ACT_BUTTON = 3'd3,
		ACT_CLEAR  = 3'd4
	} action_t;

	localparam int          KEY_ROWS_DEF = 10;
	localparam logic [15:0] ADDR_PORT1   = 16'h4016;
	localparam logic [15:0] ADDR_PORT2   = 16'h4017;
	localparam logic [7:0]  OPEN_MASK    = 8'hE0;
	localparam logic [7:0]  KBD_BITS     = 8'h1E;
	localparam logic [7:0]  ZAPPER_BITS  = 8'h09;
	localparam logic [7:0]  EXP_BIT3     = 8'h08;
	localparam logic [3:0]  POS_END      = 4'd8;

	// register indexes on the config port
	localparam logic REG_ZAPPER    = 1'b0;
	localparam logic REG_EXPANSION = 1'b1;

	typedef struct packed {
		logic [2:0]  action;
		logic [15:0] bus_addr;
		logic [7:0]  write_data;
		logic [7:0]  open_bus;
		logic        cycle_odd;
		logic        pad_select;
		logic [2:0]  button_index;
		logic        pressed;
	} item_t;

	typedef struct packed {
		logic zapper_mode;
		logic expansion_bit3_mode;
	} cfg_t;

	typedef struct packed {
		logic [3:0] pos0;
		logic [3:0] pos1;
		logic [1:0] pending_ticks;
	} status_t;

endpackage

>>> design/game_pad_serial_port.sv
// top level of the game pad serial port: stream ports, config registers, result register
//
//  channel   dir  signals                              contents
//  s_*       in   s_tvalid s_tready s_tdata s_tuser    one bus access, tick or button event
//  m_*       out  m_tvalid m_tready m_tdata            byte returned for a bus read
//  apb       in   psel penable pwrite paddr pwdata     zapper_mode at 0x0, expansion_bit3_mode at 0x4
//
// one beat per cycle sustained while no read beat waits: a beat is registered, then applied
// to the controller state as it leaves the input register, while the next beat is taken in
// a read beat waits in the input register only while the result register is full and
// m_tready is low; all other beats never wait
// reset clears all controller state, pending write, config and both valid flags
module game_pad_serial_port #(
	parameter int KEY_ROWS = gpsp_pkg::KEY_ROWS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // bus_addr, write_data, open_bus, cycle_odd, pad_select,
	                              // button_index, pressed, zero fill
	input  logic [2:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // read_data
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import gpsp_pkg::*;

	// input stage
	logic    valid_s1;
	item_t   item_s1;
	// result stage
	logic       out_valid_q;
	logic [7:0] out_data_q;
	// config
	cfg_t    cfg_q;

	logic       is_read;
	logic       out_free;
	logic       step;
	logic [7:0] rd_data;
	status_t    status;
	item_t      in_item;

	assign in_item.action       = s_tuser;
	assign in_item.bus_addr     = s_tdata[15:0];
	assign in_item.write_data   = s_tdata[23:16];
	assign in_item.open_bus     = s_tdata[31:24];
	assign in_item.cycle_odd    = s_tdata[32];
	assign in_item.pad_select   = s_tdata[33];
	assign in_item.button_index = s_tdata[36:34];
	assign in_item.pressed      = s_tdata[37];

	// only a read needs room in the result register
	assign is_read  = (item_s1.action == ACT_READ);
	assign out_free = !out_valid_q || m_tready;
	assign step     = valid_s1 && (!is_read || out_free);
	assign s_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item;
		end
	end

	gpsp_core #(
		.KEY_ROWS(KEY_ROWS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.rd_data(rd_data),
		.status (status)
	);

	// result register, refilled in the same cycle it drains
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && is_read) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && is_read) begin
			out_data_q <= rd_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// config port, register index in paddr bit 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (paddr[2])
				REG_ZAPPER:    cfg_q.zapper_mode         <= pwdata[0];
				REG_EXPANSION: cfg_q.expansion_bit3_mode <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		prdata = 32'd0;
		unique case (paddr[2])
			REG_ZAPPER:    prdata = {31'd0, cfg_q.zapper_mode};
			REG_EXPANSION: prdata = {31'd0, cfg_q.expansion_bit3_mode};
			default: begin
			end
		endcase
	end

	assign pready = 1'b1;

	// an empty input register always takes a beat
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> s_tready) else $error("input stage empty but not ready");

	// a new result only follows an applied read beat
	a_result_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(step && is_read))
		else $error("result without a read beat");

	// read positions stop at eight
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.pos0 <= POS_END && status.pos1 <= POS_END)
		else $error("read position beyond eight");

	// write delay is one or two ticks
	a_ticks_range: assert property (@(posedge clk) disable iff (!arst_n)
		status.pending_ticks != 2'd3) else $error("bad pending tick count");

endmodule

>>> design/gpsp_core.sv
// controller state, pending write delay and read byte logic
module gpsp_core #(
	parameter int KEY_ROWS = gpsp_pkg::KEY_ROWS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  gpsp_pkg::item_t  item,
	input  gpsp_pkg::cfg_t   cfg,
	output logic [7:0]       rd_data,
	output gpsp_pkg::status_t status
);
	import gpsp_pkg::*;

	localparam logic [3:0] ROW_LAST = 4'(KEY_ROWS - 1);

	logic [7:0]  pad_q [2];
	logic [3:0]  pos_q [2];
	logic        strobe_q;
	logic [3:0]  row_q;
	logic        column_q;
	logic        kbd_q;
	logic [1:0]  ticks_q;
	logic [15:0] paddr_q;
	logic [7:0]  pdata_q;

	logic [7:0]  pad_d [2];
	logic [3:0]  pos_d [2];
	logic        strobe_d;
	logic [3:0]  row_d;
	logic        column_d;
	logic        kbd_d;
	logic [1:0]  ticks_d;
	logic [15:0] paddr_d;
	logic [7:0]  pdata_d;

	logic       port;
	logic       silent;
	logic       zap;
	logic       bit_out;
	logic [7:0] cur_pad;
	logic [3:0] cur_pos;
	logic [7:0] res;
	logic [7:0] btn_mask;

	always_comb begin
		port     = item.bus_addr[0];
		silent   = port & cfg.expansion_bit3_mode;
		zap      = cfg.zapper_mode && (item.bus_addr == ADDR_PORT2);
		cur_pad  = pad_q[port];
		cur_pos  = pos_q[port];
		btn_mask = 8'h01 << item.button_index;
		bit_out  = 1'b0;

		pad_d    = pad_q;
		pos_d    = pos_q;
		strobe_d = strobe_q;
		row_d    = row_q;
		column_d = column_q;
		kbd_d    = kbd_q;
		ticks_d  = ticks_q;
		paddr_d  = paddr_q;
		pdata_d  = pdata_q;

		// serial bit and position advance
		if (strobe_q) begin
			bit_out = !silent && cur_pad[0];
		end else if (cur_pos < POS_END) begin
			bit_out = !silent && cur_pad[cur_pos[2:0]];
		end else begin
			bit_out = !silent;
		end

		res = (item.open_bus & OPEN_MASK) | {7'd0, bit_out};
		if (item.bus_addr == ADDR_PORT2) begin
			if (cfg.expansion_bit3_mode) res = res | EXP_BIT3;
			if (kbd_q) res = res | KBD_BITS;
		end
		if (zap) begin
			res = (item.open_bus & OPEN_MASK) | ZAPPER_BITS;
		end

		unique case (item.action)
			ACT_READ: begin
				if (!zap && !strobe_q && cur_pos < POS_END && !silent) begin
					pos_d[port] = cur_pos + 4'd1;
				end
			end
			ACT_WRITE: begin
				paddr_d = item.bus_addr;
				pdata_d = item.write_data;
				ticks_d = item.cycle_odd ? 2'd1 : 2'd2;
			end
			ACT_TICK: begin
				if (ticks_q != 2'd0) begin
					ticks_d = ticks_q - 2'd1;
					if (ticks_q == 2'd1 && paddr_q == ADDR_PORT1) begin
						// applied write to the strobe register
						if (strobe_q || pdata_q[0]) begin
							pos_d[0] = 4'd0;
							pos_d[1] = 4'd0;
						end
						strobe_d = pdata_q[0];
						column_d = pdata_q[1];
						if (column_q && !pdata_q[1]) begin
							row_d = (row_q == ROW_LAST) ? 4'd0 : row_q + 4'd1;
						end
						if (pdata_q[0]) row_d = 4'd0;
						kbd_d = pdata_q[2];
					end
				end
			end
			ACT_BUTTON: begin
				if (item.pressed) begin
					pad_d[item.pad_select] = pad_q[item.pad_select] | btn_mask;
				end else begin
					pad_d[item.pad_select] = pad_q[item.pad_select] & ~btn_mask;
				end
			end
			ACT_CLEAR: begin
				pad_d[0] = 8'd0;
				pad_d[1] = 8'd0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pad_q[0] <= 8'd0;
			pad_q[1] <= 8'd0;
			pos_q[0] <= 4'd0;
			pos_q[1] <= 4'd0;
			strobe_q <= 1'b0;
			row_q    <= 4'd0;
			column_q <= 1'b0;
			kbd_q    <= 1'b0;
			ticks_q  <= 2'd0;
			paddr_q  <= 16'd0;
			pdata_q  <= 8'd0;
		end else if (step) begin
			pad_q    <= pad_d;
			pos_q    <= pos_d;
			strobe_q <= strobe_d;
			row_q    <= row_d;
			column_q <= column_d;
			kbd_q    <= kbd_d;
			ticks_q  <= ticks_d;
			paddr_q  <= paddr_d;
			pdata_q  <= pdata_d;
		end
	end

	assign rd_data              = res;
	assign status.pos0          = pos_q[0];
	assign status.pos1          = pos_q[1];
	assign status.pending_ticks = ticks_q;

endmodule

>>> bench/game_pad_serial_port_tb.sv
// self-checking testbench of the game pad serial port: random and directed stream beats
`timescale 1ns / 100ps

module game_pad_serial_port_tb;
	import gpsp_pkg::*;

	// actions past ACT_CLEAR carry no meaning and must be ignored by the block
	localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
	// cycles with no beat on either side before the run is declared hung
	localparam int QUIET_LIMIT = 2000;
	// cycles for a registered beat to settle into the controller state
	localparam int SETTLE_CYCLES = 4;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;  // bus_addr, write_data, open_bus, cycle_odd, pad_select,
	                            // button_index, pressed, zero fill
	logic [2:0]  s_tuser = '0;  // action
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;       // read_data
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	game_pad_serial_port dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// controller state as the block should hold it
	// ---------------------------------------------------------------
	logic [7:0]  btn_state [2] = '{8'h00, 8'h00};
	logic [3:0]  read_pos [2] = '{4'd0, 4'd0};
	logic        strobe_q = 1'b0;
	logic [3:0]  kbd_row = '0;
	logic        kbd_col = 1'b0;
	logic        kbd_on = 1'b0;
	logic [1:0]  wr_ticks = '0;
	logic [15:0] wr_addr = '0;
	logic [7:0]  wr_byte = '0;
	logic        zapper_on = 1'b0;
	logic        expansion_on = 1'b0;

	// bytes the block owes for reads already taken in, oldest first
	logic [7:0]  read_bytes_due [$];
	item_t       beat_queue [$];
	item_t       beat_now;

	int beats_pushed = 0;
	int beats_sent = 0;
	int reads_checked = 0;
	int settings_run = 0;
	int fail_count = 0;
	int stall_pct = 14;
	int quiet_cycles = 0;
	logic hold_src = 1'b0;

	// a delayed write reaching 0x4016: strobe, read positions and keyboard row
	function automatic void latch_write(logic [7:0] d);
		logic old_col;
		old_col = kbd_col;
		if (strobe_q || d[0]) begin
			read_pos[0] = '0;
			read_pos[1] = '0;
		end
		strobe_q = d[0];
		kbd_col = d[1];
		// falling column steps the row, wrapping at the row count
		if (old_col && !kbd_col)
			kbd_row = (kbd_row == 4'(KEY_ROWS_DEF - 1)) ? 4'd0 : kbd_row + 4'd1;
		if (d[0])
			kbd_row = '0;
		kbd_on = d[2];
	endfunction

	// byte returned for a read; advances the serial position of the port
	function automatic logic [7:0] port_read(logic [15:0] addr, logic [7:0] bus);
		logic       port;
		logic       quiet;
		logic       bit_v;
		logic [7:0] res;
		port = addr[0];
		quiet = port && expansion_on;
		res = bus & OPEN_MASK;
		bit_v = 1'b0;
		// light gun on port two: fixed pattern, no state change
		if (zapper_on && addr == ADDR_PORT2)
			return res | ZAPPER_BITS;
		if (strobe_q) begin
			if (!quiet)
				bit_v = btn_state[port][0];
		end else if (read_pos[port] < POS_END) begin
			if (!quiet) begin
				bit_v = btn_state[port][read_pos[port][2:0]];
				read_pos[port] = read_pos[port] + 4'd1;
			end
		end else begin
			// past the eighth bit a standard pad reads as one
			bit_v = !quiet;
		end
		res[0] = bit_v;
		if (addr == ADDR_PORT2) begin
			if (expansion_on)
				res = res | EXP_BIT3;
			if (kbd_on)
				res = res | KBD_BITS;
		end
		return res;
	endfunction

	function automatic void pad_port_apply(item_t b);
		case (b.action)
			ACT_READ: read_bytes_due.push_back(port_read(b.bus_addr, b.open_bus));
			ACT_WRITE: begin
				// a newer write replaces a pending one and restarts the delay
				wr_addr = b.bus_addr;
				wr_byte = b.write_data;
				wr_ticks = b.cycle_odd ? 2'd1 : 2'd2;
			end
			ACT_TICK: begin
				if (wr_ticks != 0) begin
					wr_ticks = wr_ticks - 2'd1;
					if (wr_ticks == 0 && wr_addr == ADDR_PORT1)
						latch_write(wr_byte);
				end
			end
			ACT_BUTTON: btn_state[b.pad_select][b.button_index] = b.pressed;
			ACT_CLEAR: begin
				btn_state[0] = '0;
				btn_state[1] = '0;
			end
			default: ;
		endcase
	endfunction

	// ---------------------------------------------------------------
	// driver: one beat from the queue per handshake, random gaps
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				pad_port_apply(beat_now);
				beats_sent++;
			end
			// valid only changes once the current beat is gone
			if (!s_tvalid || s_tready) begin
				if (beat_queue.size() != 0 && !hold_src && $urandom_range(0, 99) >= stall_pct) begin
					beat_now = beat_queue.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= beat_now.action;
					s_tdata <= {2'b00, beat_now.pressed, beat_now.button_index,
						beat_now.pad_select, beat_now.cycle_odd, beat_now.open_bus,
						beat_now.write_data, beat_now.bus_addr};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: random back-pressure, compare each read byte in order
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
			if (m_tvalid && m_tready) begin
				if (read_bytes_due.size() == 0) begin
					$error("read_data: expected none, actual %h", m_tdata);
					fail_count++;
				end else begin
					if (m_tdata !== read_bytes_due[0]) begin
						$error("read_data: expected %h, actual %h", read_bytes_due[0], m_tdata);
						fail_count++;
					end
					void'(read_bytes_due.pop_front());
					reads_checked++;
				end
			end
		end
	end

	// hang detection: no beat on either side and no register access
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ---------------------------------------------------------------
	// stimulus helpers
	// ---------------------------------------------------------------
	// every field random so that unused bits toggle too
	function automatic item_t beat_of(logic [2:0] act);
		item_t b;
		b.action = act;
		b.bus_addr = 16'($urandom);
		b.write_data = 8'($urandom);
		b.open_bus = 8'($urandom);
		b.cycle_odd = 1'($urandom);
		b.pad_select = 1'($urandom);
		b.button_index = 3'($urandom);
		b.pressed = 1'($urandom);
		return b;
	endfunction

	function automatic logic [15:0] pick_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return ADDR_PORT1;
		if (r < 8)
			return ADDR_PORT2;
		return 16'($urandom);
	endfunction

	task automatic queue_beat(item_t b);
		beat_queue.push_back(b);
		beats_pushed++;
	endtask

	task automatic push_read(logic [15:0] addr, logic [7:0] bus);
		item_t b;
		b = beat_of(ACT_READ);
		b.bus_addr = addr;
		b.open_bus = bus;
		queue_beat(b);
	endtask

	task automatic push_write(logic [15:0] addr, logic [7:0] d, logic odd);
		item_t b;
		b = beat_of(ACT_WRITE);
		b.bus_addr = addr;
		b.write_data = d;
		b.cycle_odd = odd;
		queue_beat(b);
	endtask

	task automatic push_ticks(int n);
		repeat (n) queue_beat(beat_of(ACT_TICK));
	endtask

	task automatic push_button(logic pad, logic [2:0] idx, logic press);
		item_t b;
		b = beat_of(ACT_BUTTON);
		b.pad_select = pad;
		b.button_index = idx;
		b.pressed = press;
		queue_beat(b);
	endtask

	// every beat taken in and predicted, every byte back, then let the block settle
	task automatic drain();
		while (beats_sent != beats_pushed || read_bytes_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] addr, logic [31:0] d);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// both registers are rewritten only once the block is idle
	task automatic set_config(logic zap, logic expn);
		drain();
		apb_write({REG_ZAPPER, 2'b00}, {31'd0, zap});
		zapper_on = zap;
		apb_write({REG_EXPANSION, 2'b00}, {31'd0, expn});
		expansion_on = expn;
		settings_run++;
	endtask

	task automatic add_directed();
		push_read(ADDR_PORT1, 8'hFF);           // read straight out of reset
		push_button(1'b0, 3'd0, 1'b1);
		push_button(1'b0, 3'd7, 1'b1);
		push_button(1'b1, 3'd3, 1'b1);
		push_write(ADDR_PORT1, 8'h01, 1'b1);    // odd cycle: one tick delay
		push_ticks(1);
		push_read(ADDR_PORT1, 8'h00);           // strobe high holds bit zero
		push_write(ADDR_PORT1, 8'h00, 1'b0);    // even cycle: two tick delay
		push_ticks(1);
		push_read(ADDR_PORT2, 8'h1F);           // still strobed, write pending
		push_ticks(1);
		repeat (9) push_read(ADDR_PORT1, 8'($urandom));  // eight bits, then past the end
		push_ticks(1);                          // tick with nothing pending
		push_write(ADDR_PORT2, 8'hFF, 1'b1);    // delay ends on the wrong address
		push_ticks(1);
		push_write(ADDR_PORT1, 8'h06, 1'b0);    // replaced before it lands
		push_write(ADDR_PORT1, 8'h04, 1'b1);
		push_ticks(1);
		push_read(ADDR_PORT2, 8'hE0);           // keyboard enabled
		queue_beat(beat_of(ACT_CLEAR));
		queue_beat(beat_of(ACT_UNUSED_FIRST + 3'd2));
		push_read(16'hFFFF, 8'h00);
		push_read(16'h0000, 8'hFF);
	endtask

	// mostly full latch-and-shift sequences, the rest loose accesses and noise
	task automatic add_random(int target);
		int         first;
		int         r;
		logic       odd;
		logic [7:0] d;
		first = beats_pushed;
		while (beats_pushed - first < target) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				repeat ($urandom_range(0, 3))
					push_button(1'($urandom), 3'($urandom), 1'($urandom));
				odd = 1'($urandom);
				d = 8'($urandom);
				d[0] = 1'b1;
				push_write(ADDR_PORT1, d, odd);
				push_ticks((odd ? 1 : 2) + $urandom_range(0, 1));
				if ($urandom_range(0, 3) == 0)
					push_read(pick_addr(), 8'($urandom));
				odd = 1'($urandom);
				d = 8'($urandom);
				d[0] = 1'b0;
				push_write(ADDR_PORT1, d, odd);
				push_ticks((odd ? 1 : 2) + $urandom_range(0, 1));
				repeat ($urandom_range(6, 11))
					push_read(pick_addr(), 8'($urandom));
			end else if (r < 70) begin
				// may overlap a pending write or never land
				push_write(pick_addr(), 8'($urandom), 1'($urandom));
				push_ticks($urandom_range(0, 3));
			end else if (r < 85) begin
				push_read(pick_addr(), 8'($urandom));
			end else if (r < 93) begin
				push_button(1'($urandom), 3'($urandom), 1'($urandom));
			end else if (r < 96) begin
				queue_beat(beat_of(ACT_CLEAR));
			end else if (r < 98) begin
				push_ticks(1);
			end else begin
				queue_beat(beat_of(ACT_UNUSED_FIRST + 3'($urandom_range(0, 2))));
			end
		end
	endtask

	// ---------------------------------------------------------------
	// run: reset once, then five register settings
	// ---------------------------------------------------------------
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_config(1'b0, 1'b0);
		add_directed();
		add_random(360);

		set_config(1'b1, 1'b0);
		add_random(360);

		set_config(1'b0, 1'b1);
		add_random(360);

		// both modes on, no idling on either side
		drain();
		stall_pct = 0;
		set_config(1'b1, 1'b1);
		add_random(360);

		drain();
		stall_pct = 14;
		set_config(1'b0, 1'b0);
		add_random(360);
		// halfway through, the sender waits for every byte to come back
		while (beat_queue.size() > 180)
			@(posedge clk);
		hold_src = 1'b1;
		@(posedge clk);
		while (read_bytes_due.size() != 0 || s_tvalid)
			@(posedge clk);
		hold_src = 1'b0;

		drain();
		$display("covered %0d beats and %0d read bytes over %0d register settings",
			beats_sent, reads_checked, settings_run);
		$display("light gun, expansion, keyboard, strobe and overlapping writes included");
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
